### design/gbn_pkg.sv
`default_nettype none

package gbn_pkg;

	// sequence space and buffer ring (power of two, indexes wrap naturally)
	localparam int SEQ_SPACE = 64;
	localparam int SEQ_W     = $clog2(SEQ_SPACE);
	localparam int CNT_W     = SEQ_W + 1;

	// fixed point round-trip estimator
	localparam int FRAC_BITS = 4;
	localparam int EST_W     = 24;
	localparam int TICK_W    = 32;
	localparam int TMO_W     = 16;

	// field widths
	localparam int WIN_W  = 6;
	localparam int SUM_W  = 13;
	localparam int ASEQ_W = 20;
	localparam int AACK_W = 21;
	localparam int ACKS_W = 23;
	localparam int CFG_W  = 16;
	localparam int CIDX_W = 2;

	// register reset values
	localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(8);
	localparam logic [TMO_W-1:0] TMO_RESET = TMO_W'(20);

	// configuration register indexes
	localparam logic [CIDX_W-1:0] REG_WINDOW  = CIDX_W'(0);
	localparam logic [CIDX_W-1:0] REG_TIMEOUT = CIDX_W'(1);

	typedef enum logic [1:0] {
		OP_SUBMIT = 2'd0,
		OP_ACK    = 2'd1,
		OP_TICK   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_SEND   = 2'd0,
		KIND_RESEND = 2'd1,
		KIND_STATUS = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		STS_OK        = 3'd0,
		STS_FULL      = 3'd1,
		STS_CORRUPT   = 3'd2,
		STS_NACK      = 3'd3,
		STS_DUP       = 3'd4,
		STS_MALFORMED = 3'd5,
		STS_TIMEOUT   = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_RTT,
		S_ACKFIN,
		S_FILL,
		S_RESEND,
		S_STATUS
	} state_t;

	typedef enum logic [2:0] {
		RS_IDLE,
		RS_EST,
		RS_DIFF,
		RS_DEV,
		RS_OUT
	} rtt_step_t;

	typedef struct packed {
		logic busy;
		logic done;
	} rtt_stat_t;

endpackage

`default_nettype wire

### design/gbn_slot_ram.sv
`default_nettype none

module gbn_slot_ram (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [gbn_pkg::SEQ_W-1:0]  wr_addr,
	input  wire logic [gbn_pkg::SUM_W-1:0]  wr_data,
	input  wire logic                       re,
	input  wire logic [gbn_pkg::SEQ_W-1:0]  rd_addr,
	output logic      [gbn_pkg::SUM_W-1:0]  rd_data
);

	logic [gbn_pkg::SUM_W-1:0] mem [gbn_pkg::SEQ_SPACE];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

### design/gbn_rtt.sv
`default_nettype none

module gbn_rtt (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [gbn_pkg::TICK_W-1:0]  ticks,
	input  wire logic [gbn_pkg::TICK_W-1:0]  sstart,
	output gbn_pkg::rtt_stat_t               stat,
	output logic      [gbn_pkg::TMO_W-1:0]   tmo_new
);

	localparam int SMP_HI = gbn_pkg::EST_W - gbn_pkg::FRAC_BITS;

	gbn_pkg::rtt_step_t step_q, step_d;

	logic [gbn_pkg::EST_W-1:0]  est_q, dev_q, smp_q, diff_q;
	logic [gbn_pkg::TICK_W-1:0] span;
	logic [gbn_pkg::EST_W-1:0]  smp_new;
	logic [gbn_pkg::EST_W+3:0]  est_acc;
	logic [gbn_pkg::EST_W+1:0]  dev_acc;
	logic [gbn_pkg::EST_W+2:0]  tmo_acc;
	logic [gbn_pkg::EST_W+2-gbn_pkg::FRAC_BITS:0] tmo_raw;

	// sample in fixed point, saturated to the estimator width
	assign span = ticks - sstart;
	always_comb begin
		if (span[gbn_pkg::TICK_W-1:SMP_HI] != '0) begin
			smp_new = '1;
		end else begin
			smp_new = {span[SMP_HI-1:0], {gbn_pkg::FRAC_BITS{1'b0}}};
		end
	end

	// estimate = (7 * estimate + sample) / 8
	assign est_acc = {1'b0, est_q, 3'b000} - {4'b0000, est_q} + {4'b0000, smp_q};
	// deviation = (3 * deviation + |sample - estimate|) / 4
	assign dev_acc = {dev_q, 2'b00} - {2'b00, dev_q} + {2'b00, diff_q};
	// timeout = ceiling((estimate + 4 * deviation) / 2^frac)
	assign tmo_acc = {3'b000, est_q} + {1'b0, dev_q, 2'b00}
		+ (gbn_pkg::EST_W+3)'((1 << gbn_pkg::FRAC_BITS) - 1);
	assign tmo_raw = tmo_acc[gbn_pkg::EST_W+2:gbn_pkg::FRAC_BITS];

	// saturate to 1..max
	always_comb begin
		if (tmo_raw == '0) begin
			tmo_new = gbn_pkg::TMO_W'(1);
		end else if (tmo_raw[$bits(tmo_raw)-1:gbn_pkg::TMO_W] != '0) begin
			tmo_new = '1;
		end else begin
			tmo_new = tmo_raw[gbn_pkg::TMO_W-1:0];
		end
	end

	// step sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= gbn_pkg::RS_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	always_comb begin
		step_d    = step_q;
		stat.busy = (step_q != gbn_pkg::RS_IDLE);
		stat.done = 1'b0;
		case (step_q)
			gbn_pkg::RS_IDLE: begin
				if (start) begin
					step_d = gbn_pkg::RS_EST;
				end
			end
			gbn_pkg::RS_EST:  step_d = gbn_pkg::RS_DIFF;
			gbn_pkg::RS_DIFF: step_d = gbn_pkg::RS_DEV;
			gbn_pkg::RS_DEV:  step_d = gbn_pkg::RS_OUT;
			gbn_pkg::RS_OUT: begin
				stat.done = 1'b1;
				step_d    = gbn_pkg::RS_IDLE;
			end
			default: step_d = gbn_pkg::RS_IDLE;
		endcase
	end

	// estimator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_q <= '0;
			dev_q <= '0;
		end else begin
			if (step_q == gbn_pkg::RS_EST) begin
				est_q <= est_acc[gbn_pkg::EST_W+2:3];
			end
			if (step_q == gbn_pkg::RS_DEV) begin
				dev_q <= dev_acc[gbn_pkg::EST_W+1:2];
			end
		end
	end

	// sample and difference holding registers
	always_ff @(posedge clk) begin
		if (step_q == gbn_pkg::RS_IDLE && start) begin
			smp_q <= smp_new;
		end
		if (step_q == gbn_pkg::RS_DIFF) begin
			diff_q <= (smp_q >= est_q) ? (smp_q - est_q) : (est_q - smp_q);
		end
	end

endmodule

`default_nettype wire

### design/go_back_n_sender_control.sv
// sequencing: decode in the cycle after accept; an ack that slides the window passes
//   a timer restart state, for a sampled ack after round-trip estimate, difference,
//   deviation and output steps; packets leave one per cycle while results do not
//   stall, via the slot read stage and output register, status last; a new item is
//   taken once the last status has issued; reset: asynchronous, clears window, timer,
//   estimator state to window 8, timeout 20; slot memory not cleared, read only after written
`default_nettype none

module go_back_n_sender_control (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// item channel
	input  wire logic                                 item_valid,
	output logic                                      item_stall,
	input  wire logic [1:0]                           operation,
	input  wire logic signed [gbn_pkg::SUM_W-1:0]     payload_sum,
	input  wire logic [gbn_pkg::ASEQ_W-1:0]           ack_seqnum,
	input  wire logic signed [gbn_pkg::AACK_W-1:0]    ack_acknum,
	input  wire logic signed [gbn_pkg::ACKS_W-1:0]    ack_checksum,
	input  wire logic signed [gbn_pkg::SUM_W-1:0]     ack_payload_sum,
	// result channel
	output logic                                      result_valid,
	input  wire logic                                 result_stall,
	output logic [1:0]                                kind,
	output logic [gbn_pkg::SEQ_W-1:0]                 seq_out,
	output logic signed [gbn_pkg::SUM_W-1:0]          packet_checksum,
	output logic [2:0]                                status,
	output logic [gbn_pkg::TMO_W-1:0]                 timeout_now,
	output logic                                      last,
	// configuration write channel
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [gbn_pkg::CIDX_W-1:0]           cfg_index,
	input  wire logic [gbn_pkg::CFG_W-1:0]            cfg_data
);

	localparam int CKS_X = gbn_pkg::ACKS_W + 1;

	gbn_pkg::state_t state_q, state_d;

	// latched item
	gbn_pkg::op_t                op_q;
	logic [gbn_pkg::SUM_W-1:0]   pay_q;
	logic [gbn_pkg::ASEQ_W-1:0]  aseq_q;
	logic [gbn_pkg::AACK_W-1:0]  aack_q;
	logic [gbn_pkg::ACKS_W-1:0]  acks_q;
	logic [gbn_pkg::SUM_W-1:0]   apay_q;

	// window and timer state
	logic [gbn_pkg::SEQ_W-1:0]   base_q, next_q, tail_q, rs_q;
	logic [gbn_pkg::CNT_W-1:0]   cnt_q;
	logic                        tmr_run_q, samp_en_q;
	logic [gbn_pkg::TMO_W-1:0]   tmr_rem_q, tmo_q;
	logic [gbn_pkg::TICK_W-1:0]  ticks_q, sstart_q;
	logic [gbn_pkg::WIN_W-1:0]   win_q;
	gbn_pkg::status_t            status_q;

	// read stage
	logic                        vld_s1, last_s1;
	gbn_pkg::kind_t              kind_s1;
	logic [gbn_pkg::SEQ_W-1:0]   seq_s1;
	gbn_pkg::status_t            sts_s1;
	logic [gbn_pkg::TMO_W-1:0]   tmo_s1;

	// output register
	logic                        res_vld_q, last_q;
	gbn_pkg::kind_t              kind_q;
	logic [gbn_pkg::SEQ_W-1:0]   seq_q;
	logic [gbn_pkg::SUM_W-1:0]   cks_q;
	gbn_pkg::status_t            sts_q;
	logic [gbn_pkg::TMO_W-1:0]   tmo_out_q;

	// control
	logic                        out_free, adv;
	logic                        iss, iss_last;
	gbn_pkg::kind_t              iss_kind;
	logic [gbn_pkg::SEQ_W-1:0]   iss_seq;
	logic                        ram_we, ram_re;
	logic [gbn_pkg::SEQ_W-1:0]   ram_raddr;
	logic [gbn_pkg::SUM_W-1:0]   ram_rdata;
	logic                        rtt_start;
	gbn_pkg::rtt_stat_t          rtt_stat;
	logic [gbn_pkg::TMO_W-1:0]   rtt_tmo;

	// derived window values
	logic [gbn_pkg::SEQ_W-1:0]   infl, ack_off;
	logic [gbn_pkg::WIN_W-1:0]   effw;
	logic                        can_send, buf_full, tmr_expire;
	logic [CKS_X-1:0]            ack_sum, cks_ext;
	gbn_pkg::status_t            ack_sts;
	logic                        ack_good;

	assign cfg_ready = 1'b1;
	assign infl      = next_q - base_q;
	assign buf_full  = (cnt_q >= gbn_pkg::CNT_W'(gbn_pkg::SEQ_SPACE));
	assign tmr_expire = tmr_run_q && (tmr_rem_q <= gbn_pkg::TMO_W'(1));

	// effective window, at least one and below the sequence space
	always_comb begin
		effw = (win_q == '0) ? gbn_pkg::WIN_W'(1) : win_q;
		if (effw > gbn_pkg::WIN_W'(gbn_pkg::SEQ_SPACE - 1)) begin
			effw = gbn_pkg::WIN_W'(gbn_pkg::SEQ_SPACE - 1);
		end
	end

	assign can_send = (cnt_q > {1'b0, infl})
		&& (gbn_pkg::WIN_W'(infl) < effw);

	// ack checks
	assign ack_sum = {{(CKS_X-gbn_pkg::ASEQ_W){1'b0}}, aseq_q}
		+ {{(CKS_X-gbn_pkg::AACK_W){aack_q[gbn_pkg::AACK_W-1]}}, aack_q}
		+ {{(CKS_X-gbn_pkg::SUM_W){apay_q[gbn_pkg::SUM_W-1]}}, apay_q};
	assign cks_ext = {acks_q[gbn_pkg::ACKS_W-1], acks_q};
	assign ack_off = aack_q[gbn_pkg::SEQ_W-1:0] - base_q;

	always_comb begin
		if (ack_sum != cks_ext) begin
			ack_sts = gbn_pkg::STS_CORRUPT;
		end else if (aack_q == '1) begin
			ack_sts = gbn_pkg::STS_NACK;
		end else if (({1'b0, aseq_q} != aack_q)
				|| (aack_q[gbn_pkg::AACK_W-1:gbn_pkg::SEQ_W] != '0)) begin
			ack_sts = gbn_pkg::STS_MALFORMED;
		end else if (ack_off >= infl) begin
			ack_sts = gbn_pkg::STS_DUP;
		end else begin
			ack_sts = gbn_pkg::STS_OK;
		end
	end
	assign ack_good = (ack_sts == gbn_pkg::STS_OK);

	// stage advance
	assign out_free = !res_vld_q || !result_stall;
	assign adv      = !vld_s1 || out_free;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gbn_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and issue control
	always_comb begin
		state_d    = state_q;
		item_stall = (state_q != gbn_pkg::S_IDLE);
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		ram_raddr  = next_q;
		rtt_start  = 1'b0;
		iss        = 1'b0;
		iss_last   = 1'b0;
		iss_kind   = gbn_pkg::KIND_STATUS;
		iss_seq    = '0;
		case (state_q)
			gbn_pkg::S_IDLE: begin
				if (item_valid) begin
					state_d = gbn_pkg::S_DECODE;
				end
			end
			gbn_pkg::S_DECODE: begin
				case (op_q)
					gbn_pkg::OP_SUBMIT: begin
						ram_we  = !buf_full;
						state_d = gbn_pkg::S_FILL;
					end
					gbn_pkg::OP_ACK: begin
						if (ack_good && samp_en_q) begin
							rtt_start = 1'b1;
							state_d   = gbn_pkg::S_RTT;
						end else if (ack_good) begin
							state_d = gbn_pkg::S_ACKFIN;
						end else begin
							state_d = gbn_pkg::S_FILL;
						end
					end
					gbn_pkg::OP_TICK: begin
						state_d = tmr_expire ? gbn_pkg::S_RESEND : gbn_pkg::S_FILL;
					end
					default: state_d = gbn_pkg::S_STATUS;
				endcase
			end
			gbn_pkg::S_RTT: begin
				if (rtt_stat.done) begin
					state_d = gbn_pkg::S_ACKFIN;
				end
			end
			gbn_pkg::S_ACKFIN: state_d = gbn_pkg::S_FILL;
			gbn_pkg::S_FILL: begin
				if (adv) begin
					iss = 1'b1;
					if (can_send) begin
						ram_re   = 1'b1;
						iss_kind = gbn_pkg::KIND_SEND;
						iss_seq  = next_q;
					end else begin
						iss_last = 1'b1;
						state_d  = gbn_pkg::S_IDLE;
					end
				end
			end
			gbn_pkg::S_RESEND: begin
				ram_raddr = rs_q;
				if (adv) begin
					iss = 1'b1;
					if (rs_q != next_q) begin
						ram_re   = 1'b1;
						iss_kind = gbn_pkg::KIND_RESEND;
						iss_seq  = rs_q;
					end else begin
						iss_last = 1'b1;
						state_d  = gbn_pkg::S_IDLE;
					end
				end
			end
			gbn_pkg::S_STATUS: begin
				if (adv) begin
					iss      = 1'b1;
					iss_last = 1'b1;
					state_d  = gbn_pkg::S_IDLE;
				end
			end
			default: state_d = gbn_pkg::S_IDLE;
		endcase
	end

	// window, timer and configuration state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= '0;
			next_q    <= '0;
			tail_q    <= '0;
			cnt_q     <= '0;
			tmr_run_q <= 1'b0;
			tmr_rem_q <= '0;
			ticks_q   <= '0;
			sstart_q  <= '0;
			samp_en_q <= 1'b1;
			tmo_q     <= gbn_pkg::TMO_RESET;
			win_q     <= gbn_pkg::WIN_RESET;
			vld_s1    <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			// register writes
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == gbn_pkg::REG_WINDOW) begin
					win_q <= cfg_data[gbn_pkg::WIN_W-1:0];
				end else if (cfg_index == gbn_pkg::REG_TIMEOUT) begin
					tmo_q <= (cfg_data == '0) ? gbn_pkg::TMO_W'(1) : cfg_data;
				end
			end
			case (state_q)
				gbn_pkg::S_DECODE: begin
					case (op_q)
						gbn_pkg::OP_SUBMIT: begin
							if (!buf_full) begin
								tail_q <= tail_q + 1'b1;
								cnt_q  <= cnt_q + 1'b1;
							end
						end
						gbn_pkg::OP_ACK: begin
							if (ack_good) begin
								base_q    <= aack_q[gbn_pkg::SEQ_W-1:0] + 1'b1;
								cnt_q     <= cnt_q - {1'b0, ack_off} - 1'b1;
								tmr_run_q <= 1'b0;
								tmr_rem_q <= '0;
							end
						end
						gbn_pkg::OP_TICK: begin
							ticks_q <= ticks_q + 1'b1;
							if (tmr_expire) begin
								samp_en_q <= 1'b0;
								tmr_rem_q <= tmo_q;
							end else if (tmr_run_q) begin
								tmr_rem_q <= tmr_rem_q - 1'b1;
							end
						end
						default: ;
					endcase
				end
				gbn_pkg::S_RTT: begin
					if (rtt_stat.done) begin
						tmo_q <= rtt_tmo;
					end
				end
				gbn_pkg::S_ACKFIN: begin
					// restart the timer while packets remain in flight
					if (base_q != next_q) begin
						tmr_run_q <= 1'b1;
						tmr_rem_q <= tmo_q;
						sstart_q  <= ticks_q;
					end
				end
				gbn_pkg::S_FILL: begin
					if (adv && can_send) begin
						if (infl == '0) begin
							tmr_run_q <= 1'b1;
							tmr_rem_q <= tmo_q;
							sstart_q  <= ticks_q;
							samp_en_q <= 1'b1;
						end
						next_q <= next_q + 1'b1;
					end
				end
				default: ;
			endcase
			// pipeline valids
			if (adv) begin
				vld_s1 <= iss;
			end
			if (out_free) begin
				res_vld_q <= vld_s1;
			end
		end
	end

	// item capture, status and payload pipeline
	always_ff @(posedge clk) begin
		if (state_q == gbn_pkg::S_IDLE && item_valid) begin
			op_q   <= gbn_pkg::op_t'(operation);
			pay_q  <= payload_sum;
			aseq_q <= ack_seqnum;
			aack_q <= ack_acknum;
			acks_q <= ack_checksum;
			apay_q <= ack_payload_sum;
		end
		if (state_q == gbn_pkg::S_DECODE) begin
			rs_q <= base_q;
			case (op_q)
				gbn_pkg::OP_SUBMIT: status_q <= buf_full ? gbn_pkg::STS_FULL : gbn_pkg::STS_OK;
				gbn_pkg::OP_ACK:    status_q <= ack_sts;
				gbn_pkg::OP_TICK:   status_q <= tmr_expire ? gbn_pkg::STS_TIMEOUT
					: gbn_pkg::STS_OK;
				default:            status_q <= gbn_pkg::STS_MALFORMED;
			endcase
		end
		if (state_q == gbn_pkg::S_RESEND && adv && rs_q != next_q) begin
			rs_q <= rs_q + 1'b1;
		end
		// read stage
		if (adv) begin
			kind_s1 <= iss_kind;
			seq_s1  <= iss_seq;
			last_s1 <= iss_last;
			sts_s1  <= iss_last ? status_q : gbn_pkg::STS_OK;
			tmo_s1  <= tmo_q;
		end
		// output register
		if (out_free && vld_s1) begin
			kind_q    <= kind_s1;
			seq_q     <= seq_s1;
			last_q    <= last_s1;
			sts_q     <= sts_s1;
			tmo_out_q <= tmo_s1;
			if (kind_s1 == gbn_pkg::KIND_STATUS) begin
				cks_q <= '0;
			end else begin
				cks_q <= {{(gbn_pkg::SUM_W-gbn_pkg::SEQ_W){1'b0}}, seq_s1} + ram_rdata;
			end
		end
	end

	assign result_valid    = res_vld_q;
	assign kind            = kind_q;
	assign seq_out         = seq_q;
	assign packet_checksum = cks_q;
	assign status          = sts_q;
	assign timeout_now     = tmo_out_q;
	assign last            = last_q;

	gbn_slot_ram u_ram (
		.clk     (clk),
		.we      (ram_we),
		.wr_addr (tail_q),
		.wr_data (pay_q),
		.re      (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	gbn_rtt u_rtt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (rtt_start),
		.ticks   (ticks_q),
		.sstart  (sstart_q),
		.stat    (rtt_stat),
		.tmo_new (rtt_tmo)
	);

	// packets in flight never outnumber buffered messages
	a_infl_le_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, infl} <= cnt_q)
		else $error("in-flight count exceeds buffered count");

	// a stalled read stage keeps its item
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !out_free |=> vld_s1 && $stable(seq_s1) && $stable(kind_s1))
		else $error("read stage item lost while stalled");

	// round-trip unit only runs while the sequencer waits for it
	a_rtt_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rtt_stat.busy |-> state_q == gbn_pkg::S_RTT)
		else $error("round-trip unit busy outside its state");

	// the final item of a step is exactly the status item
	a_last_status: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (last == (kind_q == gbn_pkg::KIND_STATUS)))
		else $error("last flag does not match status item");

endmodule

`default_nettype wire
